/* rtl/line_pixel_stepper_top_macros.svh */
// Assertion macros shared by the line pixel stepper RTL.
`ifndef LINE_PIXEL_STEPPER_TOP_MACROS_SVH
`define LINE_PIXEL_STEPPER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lps_pkg.sv */
// Package with the types and constants of the line pixel stepper.
package lps_pkg;

  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 6;
  localparam int unsigned ERR_W  = 10;
  localparam int unsigned BANK_W = 3;
  localparam int unsigned MASK_W = 8;
  localparam int unsigned WIDE_W = 12;

  localparam logic [COL_W-1:0] COLUMNS_RST = 7'd84;
  localparam logic [ROW_W-1:0] ROWS_RST    = 6'd48;

  // Input word action code.
  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_ADVANCE = 1'b1
  } lps_action_e;

  // Configuration register index.
  typedef enum logic {
    CFG_COLUMNS = 1'b0,
    CFG_ROWS    = 1'b1
  } lps_cfg_e;

  // Line state carried from word to word.
  typedef struct packed {
    logic [COL_W-1:0] current_x;
    logic [ROW_W-1:0] current_y;
    logic [COL_W-1:0] target_x;
    logic [ROW_W-1:0] target_y;
    logic [ERR_W-1:0] error_term;
    logic [COL_W-1:0] delta_x;
    logic [COL_W-1:0] neg_delta_y;
    logic             step_x_neg;
    logic             step_y_neg;
    logic             line_done;
  } lps_state_t;

  localparam lps_state_t LPS_STATE_RST = '{line_done: 1'b1, default: '0};

  // One result word.
  typedef struct packed {
    logic              pixel_valid;
    logic [COL_W-1:0]  pixel_x;
    logic [ROW_W-1:0]  pixel_y;
    logic [BANK_W-1:0] bank;
    logic [MASK_W-1:0] bit_mask;
    logic              on_screen;
    logic              last;
  } lps_result_t;

endpackage

/* rtl/lps_step.sv */
// One Bresenham step: next line state and the result word for one input word.
module lps_step
  import lps_pkg::*;
(
  input  lps_state_t        state_i,
  input  logic              action_i,
  input  logic [COL_W-1:0]  x_start_i,
  input  logic [ROW_W-1:0]  y_start_i,
  input  logic [COL_W-1:0]  x_end_i,
  input  logic [ROW_W-1:0]  y_end_i,
  input  logic [COL_W-1:0]  columns_i,
  input  logic [ROW_W-1:0]  rows_i,
  output lps_state_t        state_o,
  output lps_result_t       result_o
);

  logic signed [WIDE_W-1:0] err_s;
  logic signed [WIDE_W-1:0] e2_s;
  logic signed [WIDE_W-1:0] dy_s;
  logic signed [WIDE_W-1:0] dx_s;
  logic signed [WIDE_W-1:0] err_a;
  logic signed [WIDE_W-1:0] err_b;
  logic                     x_due;
  logic                     y_due;
  logic [ROW_W-1:0]         ady;
  logic [COL_W-1:0]         sdx;
  logic [ERR_W-1:0]         start_err;

  // Error-term arithmetic, extended to a common signed width (delta_x zero extended).
  assign err_s = {{(WIDE_W-ERR_W){state_i.error_term[ERR_W-1]}}, state_i.error_term};
  assign e2_s  = err_s <<< 1;
  assign dy_s  = {{(WIDE_W-COL_W){state_i.neg_delta_y[COL_W-1]}}, state_i.neg_delta_y};
  assign dx_s  = {{(WIDE_W-COL_W){1'b0}}, state_i.delta_x};
  assign x_due = (e2_s >= dy_s);
  assign y_due = (e2_s <= dx_s);
  assign err_a = x_due ? err_s + dy_s : err_s;
  assign err_b = y_due ? err_a + dx_s : err_a;

  // Start values taken from the endpoints.
  assign ady       = (y_end_i > y_start_i) ? y_end_i - y_start_i : y_start_i - y_end_i;
  assign sdx       = (x_end_i > x_start_i) ? x_end_i - x_start_i : x_start_i - x_end_i;
  assign start_err = {{(ERR_W-COL_W){1'b0}}, sdx} - {{(ERR_W-ROW_W){1'b0}}, ady};

  // Next state and whether a pixel goes out.
  always_comb begin
    lps_state_t nxt;
    logic       emit;
    nxt  = state_i;
    emit = 1'b0;
    if (action_i == ACT_START) begin
      nxt.current_x   = x_start_i;
      nxt.current_y   = y_start_i;
      nxt.target_x    = x_end_i;
      nxt.target_y    = y_end_i;
      nxt.delta_x     = sdx;
      nxt.neg_delta_y = COL_W'(0) - {1'b0, ady};
      nxt.step_x_neg  = !(x_start_i < x_end_i);
      nxt.step_y_neg  = !(y_start_i < y_end_i);
      nxt.error_term  = start_err;
      nxt.line_done   = 1'b0;
      emit            = 1'b1;
    end else if (state_i.line_done) begin
      emit = 1'b0;
    end else if (x_due && (state_i.current_x == state_i.target_x)) begin
      // Horizontal move due with no room left: the line breaks.
      nxt.line_done = 1'b1;
    end else begin
      if (x_due) begin
        nxt.current_x = state_i.step_x_neg ? state_i.current_x - 1'b1
                                           : state_i.current_x + 1'b1;
      end
      if (y_due && (state_i.current_y == state_i.target_y)) begin
        // Vertical break keeps the horizontal move already made.
        nxt.error_term = err_a[ERR_W-1:0];
        nxt.line_done  = 1'b1;
      end else begin
        if (y_due) begin
          nxt.current_y = state_i.step_y_neg ? state_i.current_y - 1'b1
                                             : state_i.current_y + 1'b1;
        end
        nxt.error_term = err_b[ERR_W-1:0];
        emit           = 1'b1;
      end
    end

    // Result word from the new position; reaching the end point closes the line.
    result_o = '0;
    if (emit) begin
      result_o.pixel_valid = 1'b1;
      result_o.pixel_x     = nxt.current_x;
      result_o.pixel_y     = nxt.current_y;
      result_o.bank        = nxt.current_y[ROW_W-1:ROW_W-BANK_W];
      result_o.bit_mask    = MASK_W'(1) << nxt.current_y[BANK_W-1:0];
      result_o.on_screen   = (nxt.current_x < columns_i) && (nxt.current_y < rows_i);
      result_o.last        = (nxt.current_x == nxt.target_x) &&
                             (nxt.current_y == nxt.target_y);
      if (result_o.last) begin
        nxt.line_done = 1'b1;
      end
    end
    state_o = nxt;
  end

endmodule

/* rtl/line_pixel_stepper_top.sv */
// Top level of the line pixel stepper: handshakes, state, config and result register.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o  | action, x_start, y_start, x_end, y_end
//  out     | output    | out_valid_o/out_ready_i| pixel_valid, pixel_x, pixel_y, bank,
//          |           |                        | bit_mask, on_screen, last
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// Each input word yields exactly one result word, registered and valid in the cycle after acceptance.
// One word per cycle while out_ready_i is high: the step logic runs between the line state and the result register.
// A stalled result blocks input only while out_ready_i is low.
// Reset clears the line (no line active) and loads 84 columns by 48 rows.
`include "line_pixel_stepper_top_macros.svh"

module line_pixel_stepper_top
  import lps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              action_i,
  input  logic [COL_W-1:0]  x_start_i,
  input  logic [ROW_W-1:0]  y_start_i,
  input  logic [COL_W-1:0]  x_end_i,
  input  logic [ROW_W-1:0]  y_end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              pixel_valid_o,
  output logic [COL_W-1:0]  pixel_x_o,
  output logic [ROW_W-1:0]  pixel_y_o,
  output logic [BANK_W-1:0] bank_o,
  output logic [MASK_W-1:0] bit_mask_o,
  output logic              on_screen_o,
  output logic              last_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [COL_W-1:0]  cfg_wdata_i
);

  lps_state_t       state_q, state_d;
  lps_result_t      res_q, res_d;
  logic             out_valid_q;
  logic [COL_W-1:0] columns_q;
  logic [ROW_W-1:0] rows_q;
  logic             in_fire;

  // Input is taken whenever the result register is empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Step logic.
  lps_step u_step (
    .state_i   (state_q),
    .action_i  (action_i),
    .x_start_i (x_start_i),
    .y_start_i (y_start_i),
    .x_end_i   (x_end_i),
    .y_end_i   (y_end_i),
    .columns_i (columns_q),
    .rows_i    (rows_q),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  // Line state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LPS_STATE_RST;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLUMNS_RST;
      rows_q    <= ROWS_RST;
    end else if (cfg_we_i) begin
      unique case (lps_cfg_e'(cfg_idx_i))
        CFG_COLUMNS: columns_q <= cfg_wdata_i;
        CFG_ROWS:    rows_q    <= cfg_wdata_i[ROW_W-1:0];
        default:     columns_q <= columns_q;
      endcase
    end
  end

  // Output ports.
  assign out_valid_o   = out_valid_q;
  assign pixel_valid_o = res_q.pixel_valid;
  assign pixel_x_o     = res_q.pixel_x;
  assign pixel_y_o     = res_q.pixel_y;
  assign bank_o        = res_q.bank;
  assign bit_mask_o    = res_q.bit_mask;
  assign on_screen_o   = res_q.on_screen;
  assign last_o        = res_q.last;

  // Checks on the step and result logic.
  `LPS_ASSERT_NEXT(a_fire_gives_word, clk_i, rst_ni, in_fire, out_valid_o,
    "accepted word did not produce a result")
  `LPS_ASSERT_NEXT(a_last_ends_line, clk_i, rst_ni,
    in_fire && res_d.pixel_valid && res_d.last, state_q.line_done,
    "line still active after its end pixel")
  `LPS_ASSERT_NEXT(a_idle_advance_empty, clk_i, rst_ni,
    in_fire && (action_i == ACT_ADVANCE) && state_q.line_done,
    !pixel_valid_o && state_q.line_done,
    "advance without an active line produced a pixel")
  `LPS_ASSERT_SAME(a_empty_word_zero, clk_i, rst_ni, out_valid_o && !pixel_valid_o,
    (pixel_x_o == '0) && (bit_mask_o == '0) && !last_o && !on_screen_o,
    "word without a pixel carries nonzero fields")

endmodule

/* tb/line_pixel_stepper_top_tb.sv */
// Self-checking testbench for the line pixel stepper with its own Bresenham predictor.
`timescale 1ns / 100ps

module line_pixel_stepper_top_tb;
  import lps_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              action_i;
  logic [COL_W-1:0]  x_start_i;
  logic [ROW_W-1:0]  y_start_i;
  logic [COL_W-1:0]  x_end_i;
  logic [ROW_W-1:0]  y_end_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              pixel_valid_o;
  logic [COL_W-1:0]  pixel_x_o;
  logic [ROW_W-1:0]  pixel_y_o;
  logic [BANK_W-1:0] bank_o;
  logic [MASK_W-1:0] bit_mask_o;
  logic              on_screen_o;
  logic              last_o;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [COL_W-1:0]  cfg_wdata_i;

  // Predictor copy of the line state and of the display size.
  lps_state_t        line_st;
  logic [COL_W-1:0]  columns_cfg;
  logic [ROW_W-1:0]  rows_cfg;
  lps_result_t       pending_pixels[$];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req   = 1'b0;
  int err_cnt       = 0;
  int words_sent    = 0;
  int pixels_seen   = 0;
  int blanks_seen   = 0;
  int settings_used = 0;

  line_pixel_stepper_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_valid_o(pixel_valid_o),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .bank_o       (bank_o),
    .bit_mask_o   (bit_mask_o),
    .on_screen_o  (on_screen_o),
    .last_o       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Free-running clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Computes the result word of one input word and advances the line state.
  function automatic lps_result_t trace_pixel(input lps_action_e act,
                                              input logic [COL_W-1:0] xs,
                                              input logic [ROW_W-1:0] ys,
                                              input logic [COL_W-1:0] xe,
                                              input logic [ROW_W-1:0] ye);
    lps_result_t pix;
    int          err;
    int          dy;
    int          dx;
    int          e2;
    int          ady;
    bit          emit;
    pix  = '0;
    emit = 1'b1;
    if (act == ACT_START) begin
      ady = (ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
      line_st.current_x   = xs;
      line_st.current_y   = ys;
      line_st.target_x    = xe;
      line_st.target_y    = ye;
      line_st.delta_x     = (xe > xs) ? xe - xs : xs - xe;
      line_st.neg_delta_y = COL_W'(-ady);
      line_st.step_x_neg  = !(xs < xe);
      line_st.step_y_neg  = !(ys < ye);
      line_st.error_term  = ERR_W'(int'(line_st.delta_x) - ady);
      line_st.line_done   = 1'b0;
    end else if (line_st.line_done) begin
      // Advance with no active line gives no pixel and leaves the state alone.
      emit = 1'b0;
    end else begin
      err = int'($signed(line_st.error_term));
      dy  = int'($signed(line_st.neg_delta_y));
      dx  = int'(line_st.delta_x);
      e2  = 2 * err;
      // A due move along an axis that already sits on its target breaks the line.
      if (e2 >= dy) begin
        if (line_st.current_x == line_st.target_x) begin
          line_st.line_done = 1'b1;
          emit = 1'b0;
        end else begin
          err += dy;
          line_st.current_x = line_st.step_x_neg ? line_st.current_x - 1'b1
                                                 : line_st.current_x + 1'b1;
        end
      end
      if (emit && e2 <= dx) begin
        if (line_st.current_y == line_st.target_y) begin
          line_st.line_done = 1'b1;
          emit = 1'b0;
        end else begin
          err += dx;
          line_st.current_y = line_st.step_y_neg ? line_st.current_y - 1'b1
                                                 : line_st.current_y + 1'b1;
        end
      end
      line_st.error_term = ERR_W'(err);
    end
    if (emit) begin
      pix.pixel_valid = 1'b1;
      pix.pixel_x     = line_st.current_x;
      pix.pixel_y     = line_st.current_y;
      pix.bank        = line_st.current_y[5:3];
      pix.bit_mask    = MASK_W'(1) << line_st.current_y[2:0];
      pix.on_screen   = (line_st.current_x < columns_cfg) && (line_st.current_y < rows_cfg);
      pix.last        = (line_st.current_x == line_st.target_x) &&
                        (line_st.current_y == line_st.target_y);
      if (pix.last) begin
        line_st.line_done = 1'b1;
      end
    end
    return pix;
  endfunction

  // Offers one word, holds it until accepted, then queues its expected result.
  task automatic send_word(input lps_action_e act, input logic [COL_W-1:0] xs,
                           input logic [ROW_W-1:0] ys, input logic [COL_W-1:0] xe,
                           input logic [ROW_W-1:0] ye);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    x_start_i  <= xs;
    y_start_i  <= ys;
    x_end_i    <= xe;
    y_end_i    <= ye;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_pixels.push_back(trace_pixel(act, xs, ys, xe, ye));
    words_sent++;
  endtask

  // Sends a start word and then as many advance words as the line needs plus extra.
  task automatic run_line(input logic [COL_W-1:0] xs, input logic [ROW_W-1:0] ys,
                          input logic [COL_W-1:0] xe, input logic [ROW_W-1:0] ye,
                          input int extra);
    int dxa;
    int dya;
    int steps;
    dxa   = (xe > xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
    dya   = (ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
    steps = ((dxa > dya) ? dxa : dya) + extra;
    send_word(ACT_START, xs, ys, xe, ye);
    repeat ((steps < 0) ? 0 : steps) begin
      send_word(ACT_ADVANCE, COL_W'($urandom), ROW_W'($urandom), COL_W'($urandom),
                ROW_W'($urandom));
    end
  endtask

  // Waits until every queued result has come back and the block is quiet.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Writes both display size registers; only called while the block is idle.
  task automatic set_display(input logic [COL_W-1:0] cols, input logic [ROW_W-1:0] rows);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_COLUMNS;
    cfg_wdata_i <= cols;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_ROWS;
    cfg_wdata_i <= {1'b0, rows};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    columns_cfg = cols;
    rows_cfg    = rows;
    settings_used++;
  endtask

  // Result checker: every accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    lps_result_t got;
    lps_result_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {pixel_valid_o, pixel_x_o, pixel_y_o, bank_o, bit_mask_o, on_screen_o, last_o};
      if (pending_pixels.size() == 0) begin
        $error("Result word with no expectation pending");
        err_cnt++;
      end else begin
        exp = pending_pixels.pop_front();
        if (got.pixel_valid) pixels_seen++;
        else blanks_seen++;
        if (got.pixel_valid !== exp.pixel_valid) begin
          $error("pixel_valid: expected %0d, actual %0d", exp.pixel_valid, got.pixel_valid);
          err_cnt++;
        end
        if (got.pixel_x !== exp.pixel_x) begin
          $error("pixel_x: expected %0d, actual %0d", exp.pixel_x, got.pixel_x);
          err_cnt++;
        end
        if (got.pixel_y !== exp.pixel_y) begin
          $error("pixel_y: expected %0d, actual %0d", exp.pixel_y, got.pixel_y);
          err_cnt++;
        end
        if (got.bank !== exp.bank) begin
          $error("bank: expected %0d, actual %0d", exp.bank, got.bank);
          err_cnt++;
        end
        if (got.bit_mask !== exp.bit_mask) begin
          $error("bit_mask: expected %h, actual %h", exp.bit_mask, got.bit_mask);
          err_cnt++;
        end
        if (got.on_screen !== exp.on_screen) begin
          $error("on_screen: expected %0d, actual %0d", exp.on_screen, got.on_screen);
          err_cnt++;
        end
        if (got.last !== exp.last) begin
          $error("last: expected %0d, actual %0d", exp.last, got.last);
          err_cnt++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  always begin
    if (hold_req) begin
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_req = 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end else begin
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Advance with no line active right after reset.
  task automatic test_idle_advance;
    send_word(ACT_ADVANCE, '1, '1, '1, '1);
    send_word(ACT_ADVANCE, '0, '0, '0, '0);
  endtask

  // Hand-picked lines: single point, full diagonal, restart, axis lines, screen edge.
  task automatic test_directed_lines;
    run_line(7'd5, 6'd5, 7'd5, 6'd5, 1);
    run_line(7'd0, 6'd0, 7'd127, 6'd63, -124);
    run_line(7'd127, 6'd63, 7'd120, 6'd60, 1);
    run_line(7'd10, 6'd0, 7'd10, 6'd3, 0);
    run_line(7'd3, 6'd20, 7'd0, 6'd20, 0);
    run_line(7'd83, 6'd47, 7'd84, 6'd48, 1);
  endtask

  // Display size extremes, zero size included, with lines across the edges.
  task automatic test_display_limits;
    logic [COL_W-1:0] cols_list[5] = '{7'd0, 7'd1, 7'd127, 7'd84, 7'd0};
    logic [ROW_W-1:0] rows_list[5] = '{6'd0, 6'd1, 6'd63, 6'd0, 6'd48};
    for (int i = 0; i < 5; i++) begin
      drain();
      set_display(cols_list[i], rows_list[i]);
      run_line(7'd0, 6'd0, 7'd3, 6'd2, 0);
      run_line(7'd126, 6'd62, 7'd127, 6'd63, 0);
      run_line(COL_W'($urandom), ROW_W'($urandom), COL_W'($urandom), ROW_W'($urandom),
               -int'($urandom_range(0, 40)));
    end
  endtask

  // Receiver holds off while words keep coming, so the block backs up.
  task automatic test_output_stall;
    drain();
    hold_req = 1'b1;
    repeat (4) begin
      run_line(COL_W'($urandom), ROW_W'($urandom), COL_W'($urandom), ROW_W'($urandom), 0);
    end
  endtask

  // Random lines, cut-short lines and loose words at a random display size.
  task automatic test_random_lines(input int n_words);
    int               first;
    int               kind;
    logic [COL_W-1:0] xs;
    logic [COL_W-1:0] xe;
    logic [ROW_W-1:0] ys;
    logic [ROW_W-1:0] ye;
    first = words_sent;
    while (words_sent - first < n_words) begin
      kind = $urandom_range(0, 9);
      xs   = COL_W'($urandom);
      ys   = ROW_W'($urandom);
      if ($urandom_range(0, 5) == 0) begin
        xe = COL_W'($urandom);
        ye = ROW_W'($urandom);
      end else begin
        xe = xs + COL_W'($urandom_range(0, 16)) - 7'd8;
        ye = ys + ROW_W'($urandom_range(0, 12)) - 6'd6;
      end
      if (kind == 0) begin
        send_word(lps_action_e'($urandom_range(0, 1)), COL_W'($urandom), ROW_W'($urandom),
                  COL_W'($urandom), ROW_W'($urandom));
      end else if (kind == 1) begin
        run_line(xs, ys, xe, ye, -int'($urandom_range(1, 4)));
      end else begin
        run_line(xs, ys, xe, ye, int'($urandom_range(0, 2)));
      end
    end
  endtask

  // Several random phases, each at its own display size; the last runs with no idling.
  task automatic test_random_traffic;
    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] rows;
    for (int phase = 0; phase < 5; phase++) begin
      cols = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? 7'd127 : 7'd1)
                                         : COL_W'($urandom);
      rows = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? 6'd63 : 6'd1)
                                         : ROW_W'($urandom);
      drain();
      set_display(cols, rows);
      if (phase == 4) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      test_random_lines(185);
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    action_i    <= ACT_START;
    x_start_i   <= '0;
    y_start_i   <= '0;
    x_end_i     <= '0;
    y_end_i     <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_COLUMNS;
    cfg_wdata_i <= '0;
    line_st     = LPS_STATE_RST;
    columns_cfg = COLUMNS_RST;
    rows_cfg    = ROWS_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_advance();
    test_directed_lines();
    test_display_limits();
    test_output_stall();
    test_random_traffic();

    drain();
    repeat (5) @(posedge clk_i);
    $display("Sent %0d words: %0d pixels and %0d no-pixel words checked.",
             words_sent, pixels_seen, blanks_seen);
    $display("Covered %0d display size settings and a %0d-cycle output hold-off.",
             settings_used, HOLD_CYCLES);
    if (err_cnt == 0 && pending_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout waiting for the block");
    $display("Regression FAIL");
    $finish;
  end

endmodule
